/* hdl/tfn_pkg.sv */
// Shared constants for the triangle face normal pipeline.
package tfn_pkg;

	// Number of vector components handled in parallel lanes.
	localparam int AXES = 3;

	// Lane index of each component.
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	// Number of vertex coordinates in one input transaction.
	localparam int COORDS = 9;

endpackage

/* hdl/triangle_face_normal.sv */
// Streaming unit face normal of a triangle, pipelined over square root and division stages.
//
// Each input transaction carries three vertices in signed fixed point. The block forms
// the edges v1-v0 and v2-v0, their exact cross product c, the integer length
// L = floor(sqrt(cx^2 + cy^2 + cz^2)) and then each component as c * 2^FRAC_BITS / L,
// truncated toward zero. When the cross product is zero the degenerate flag in tuser
// is set and all three components read zero. The block accepts one transaction in
// every clock cycle while its results are taken and returns one result transaction
// per input in order. The pipeline is built from six front-end stages (edges,
// products, cross terms, magnitudes, split square products, sum of squares), one
// stage per root bit in the square root, one stage per quotient bit in the three
// parallel dividers, and the output register. The whole pipeline
// advances together; while the output register holds a result that is not taken,
// s_axis_tready is low and nothing moves, so no transaction is lost or repeated.
module triangle_face_normal #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill
	input  logic [((tfn_pkg::COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// normal_x, normal_y, normal_z, zero fill
	output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
	// degenerate
	output logic m_axis_tuser
);

	// Edge width, cross product width and magnitude width.
	localparam int EW  = COORD_WIDTH + 1;
	localparam int CW  = 2 * EW;
	localparam int CM  = CW - 1;
	// Split of a magnitude into high and low halves for squaring.
	localparam int KL  = (CM + 1) / 2;
	localparam int KH  = CM - KL;
	// Sum of squares, root and result widths.
	localparam int SW  = 2 * CM + 2;
	localparam int RW  = CM + 1;
	localparam int QW  = FRAC_BITS + 1;
	localparam int NW  = FRAC_BITS + 2;
	localparam int OUT_W = ((3 * NW + 7) / 8) * 8;
	localparam int NA  = tfn_pkg::AXES;

	logic en;
	logic out_vld_q;

	// The entire pipeline moves when the output register is free or being drained.
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: edge vectors.
	logic signed [COORD_WIDTH-1:0] vtx [tfn_pkg::COORDS];
	logic signed [EW-1:0] ea_s1 [NA];
	logic signed [EW-1:0] eb_s1 [NA];
	logic                 vld_s1;

	always_comb begin
		for (int k = 0; k < tfn_pkg::COORDS; k++) begin
			vtx[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				ea_s1[i] <= EW'(vtx[NA + i]) - EW'(vtx[i]);
				eb_s1[i] <= EW'(vtx[2*NA + i]) - EW'(vtx[i]);
			end
		end
	end

	// Stage 2: the two products of each cross term.
	logic signed [CW-1:0] pa_s2 [NA];
	logic signed [CW-1:0] pb_s2 [NA];
	logic                 vld_s2;

	for (genvar i = 0; i < NA; i++) begin : g_prod
		localparam int I1 = (i + 1) % NA;
		localparam int I2 = (i + 2) % NA;
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s2[i] <= CW'(ea_s1[I1]) * CW'(eb_s1[I2]);
				pb_s2[i] <= CW'(eb_s1[I1]) * CW'(ea_s1[I2]);
			end
		end
	end

	// Stage 3: signed cross product.
	logic signed [CW-1:0] c_s3 [NA];
	logic                 vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				c_s3[i] <= pa_s2[i] - pb_s2[i];
			end
		end
	end

	// Stage 4: sign and magnitude, and the zero test.
	logic [NA-1:0][CM-1:0] mag_s4;
	logic [NA-1:0]         neg_s4;
	logic                  deg_s4;
	logic                  vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				neg_s4[i] <= c_s3[i][CW-1];
				mag_s4[i] <= c_s3[i][CW-1] ? CM'(-c_s3[i]) : CM'(c_s3[i]);
			end
			deg_s4 <= (c_s3[tfn_pkg::AXIS_X] == '0) && (c_s3[tfn_pkg::AXIS_Y] == '0)
			          && (c_s3[tfn_pkg::AXIS_Z] == '0);
		end
	end

	// Stage 5: partial products of each square.
	logic [2*KH-1:0]       hh_s5 [NA];
	logic [KH+KL-1:0]      hl_s5 [NA];
	logic [2*KL-1:0]       ll_s5 [NA];
	logic [NA-1:0][CM-1:0] mag_s5;
	logic [NA-1:0]         neg_s5;
	logic                  deg_s5;
	logic                  vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				hh_s5[i] <= (2*KH)'(mag_s4[i][CM-1:KL]) * (2*KH)'(mag_s4[i][CM-1:KL]);
				hl_s5[i] <= (KH+KL)'(mag_s4[i][CM-1:KL]) * (KH+KL)'(mag_s4[i][KL-1:0]);
				ll_s5[i] <= (2*KL)'(mag_s4[i][KL-1:0]) * (2*KL)'(mag_s4[i][KL-1:0]);
			end
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
		end
	end

	// Stage 6: sum of squares.
	logic [SW-1:0]         sum_s6;
	logic [NA-1:0][CM-1:0] mag_s6;
	logic [NA-1:0]         neg_s6;
	logic                  deg_s6;
	logic                  vld_s6;
	logic [SW-1:0]         sum_d;

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NA; i++) begin
			sum_d = sum_d + (SW'(hh_s5[i]) << (2*KL)) + (SW'(hl_s5[i]) << (KL+1))
			        + SW'(ll_s5[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= sum_d;
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Square root: one root bit per stage, two radicand bits consumed each time.
	logic [SW-1:0]         sqrt_rad_s  [RW];
	logic [RW:0]           sqrt_rem_s  [RW];
	logic [RW-1:0]         sqrt_root_s [RW];
	logic [NA-1:0][CM-1:0] sqrt_mag_s  [RW];
	logic [NA-1:0]         sqrt_neg_s  [RW];
	logic                  sqrt_deg_s  [RW];
	logic                  sqrt_vld_s  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [SW-1:0]         rad_i;
		logic [RW:0]           rem_i;
		logic [RW-1:0]         root_i;
		logic [NA-1:0][CM-1:0] mag_i;
		logic [NA-1:0]         neg_i;
		logic                  deg_i;
		logic                  vld_i;
		logic [RW+2:0]         rem_n;
		logic [RW+2:0]         trial;
		logic                  take;

		if (j == 0) begin : g_first
			assign rad_i  = sum_s6;
			assign rem_i  = '0;
			assign root_i = '0;
			assign mag_i  = mag_s6;
			assign neg_i  = neg_s6;
			assign deg_i  = deg_s6;
			assign vld_i  = vld_s6;
		end else begin : g_next
			assign rad_i  = sqrt_rad_s[j-1];
			assign rem_i  = sqrt_rem_s[j-1];
			assign root_i = sqrt_root_s[j-1];
			assign mag_i  = sqrt_mag_s[j-1];
			assign neg_i  = sqrt_neg_s[j-1];
			assign deg_i  = sqrt_deg_s[j-1];
			assign vld_i  = sqrt_vld_s[j-1];
		end

		assign rem_n = {rem_i, rad_i[SW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign take  = rem_n >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_rad_s[j]  <= rad_i << 2;
				sqrt_rem_s[j]  <= take ? (RW+1)'(rem_n - trial) : (RW+1)'(rem_n);
				sqrt_root_s[j] <= {root_i[RW-2:0], take};
				sqrt_mag_s[j]  <= mag_i;
				sqrt_neg_s[j]  <= neg_i;
				sqrt_deg_s[j]  <= deg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_vld_s[j] <= 1'b0;
			end else if (en) begin
				sqrt_vld_s[j] <= vld_i;
			end
		end
	end

	// Division: one quotient bit per stage, three lanes side by side sharing the length.
	logic [RW-1:0]         div_len_s [QW];
	logic [NA-1:0][RW:0]   div_rem_s [QW];
	logic [NA-1:0][QW-1:0] div_q_s   [QW];
	logic [NA-1:0]         div_neg_s [QW];
	logic                  div_deg_s [QW];
	logic                  div_vld_s [QW];

	for (genvar t = 0; t < QW; t++) begin : g_div
		logic [RW-1:0]         len_i;
		logic [NA-1:0][RW:0]   rem_i;
		logic [NA-1:0][QW-1:0] q_i;
		logic [NA-1:0]         neg_i;
		logic                  deg_i;
		logic                  vld_i;
		logic [NA-1:0][RW:0]   cand;
		logic [NA-1:0]         ge;

		if (t == 0) begin : g_first
			assign len_i = sqrt_root_s[RW-1];
			for (genvar i = 0; i < NA; i++) begin : g_lane
				assign rem_i[i] = (RW+1)'(sqrt_mag_s[RW-1][i]);
				assign cand[i]  = rem_i[i];
			end
			assign q_i   = '0;
			assign neg_i = sqrt_neg_s[RW-1];
			assign deg_i = sqrt_deg_s[RW-1];
			assign vld_i = sqrt_vld_s[RW-1];
		end else begin : g_next
			assign len_i = div_len_s[t-1];
			for (genvar i = 0; i < NA; i++) begin : g_lane
				assign rem_i[i] = div_rem_s[t-1][i];
				assign cand[i]  = {rem_i[i][RW-1:0], 1'b0};
			end
			assign q_i   = div_q_s[t-1];
			assign neg_i = div_neg_s[t-1];
			assign deg_i = div_deg_s[t-1];
			assign vld_i = div_vld_s[t-1];
		end

		always_comb begin
			for (int i = 0; i < NA; i++) begin
				ge[i] = cand[i] >= (RW+1)'(len_i);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_len_s[t] <= len_i;
				for (int i = 0; i < NA; i++) begin
					div_rem_s[t][i] <= ge[i] ? cand[i] - (RW+1)'(len_i) : cand[i];
					div_q_s[t][i]   <= {q_i[i][QW-2:0], ge[i]};
				end
				div_neg_s[t] <= neg_i;
				div_deg_s[t] <= deg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[t] <= 1'b0;
			end else if (en) begin
				div_vld_s[t] <= vld_i;
			end
		end
	end

	// Output register: sign applied, forced to zero for a degenerate triangle.
	logic [NA-1:0][NW-1:0] nrm_q;
	logic                  deg_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				if (div_deg_s[QW-1]) begin
					nrm_q[i] <= '0;
				end else if (div_neg_s[QW-1][i]) begin
					nrm_q[i] <= -NW'(div_q_s[QW-1][i]);
				end else begin
					nrm_q[i] <= NW'(div_q_s[QW-1][i]);
				end
			end
			deg_q <= div_deg_s[QW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld_s[QW-1];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'(nrm_q);
	assign m_axis_tuser  = deg_q;

	// Plus and minus one in the output format.
	localparam logic signed [NW-1:0] UNIT_POS = NW'(1 << FRAC_BITS);
	localparam logic signed [NW-1:0] UNIT_NEG = -UNIT_POS;

	// A degenerate result always carries zero components.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && deg_q |-> nrm_q == '0)
		else $error("degenerate result with nonzero normal");

	// A unit normal component never exceeds one in magnitude.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |->
		$signed(nrm_q[tfn_pkg::AXIS_X]) <= UNIT_POS &&
		$signed(nrm_q[tfn_pkg::AXIS_X]) >= UNIT_NEG &&
		$signed(nrm_q[tfn_pkg::AXIS_Y]) <= UNIT_POS &&
		$signed(nrm_q[tfn_pkg::AXIS_Y]) >= UNIT_NEG &&
		$signed(nrm_q[tfn_pkg::AXIS_Z]) <= UNIT_POS &&
		$signed(nrm_q[tfn_pkg::AXIS_Z]) >= UNIT_NEG)
		else $error("normal component out of range");

	// A result held back by the consumer stalls the input side.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// A stalled result keeps its contents until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_axis_tready |=> $stable(nrm_q) && $stable(deg_q) && out_vld_q)
		else $error("stalled result changed");

endmodule

/* sim/tb.sv */
// Self-checking stream testbench for the triangle face normal pipeline.
`timescale 1ns / 100ps

module tb;

	localparam int CW      = 16;
	localparam int FB      = 14;
	localparam int OW      = FB + 2;
	localparam int IN_W    = ((tfn_pkg::COORDS * CW + 7) / 8) * 8;
	localparam int OUT_W   = ((tfn_pkg::AXES * OW + 7) / 8) * 8;
	localparam int LATENCY = 7 + 2 * (CW + 1) + (FB + 1);
	localparam int HANG    = 4000;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t face_t [tfn_pkg::COORDS];

	typedef struct {
		logic signed [OW-1:0] comp [tfn_pkg::AXES];
		logic                 degenerate;
	} normal_t;

	// The scoreboard holds the unit normals still owed by the block, oldest first.
	class face_normal_board;
		normal_t pending [$];
		int      errors;

		// The exact integer normal: cross product, floor root of its squared length,
		// then each component scaled by 2^FB and truncated toward zero.
		function normal_t unit_normal(face_t f);
			normal_t   n;
			longint    e1 [tfn_pkg::AXES], e2 [tfn_pkg::AXES], c [tfn_pkg::AXES];
			bit [127:0] mag [tfn_pkg::AXES];
			bit [127:0] sum, len, trial, quot;
			for (int a = 0; a < tfn_pkg::AXES; a++) begin
				e1[a] = longint'(f[3 + a]) - longint'(f[a]);
				e2[a] = longint'(f[6 + a]) - longint'(f[a]);
			end
			c[tfn_pkg::AXIS_X] = e1[tfn_pkg::AXIS_Y] * e2[tfn_pkg::AXIS_Z]
				- e2[tfn_pkg::AXIS_Y] * e1[tfn_pkg::AXIS_Z];
			c[tfn_pkg::AXIS_Y] = e1[tfn_pkg::AXIS_Z] * e2[tfn_pkg::AXIS_X]
				- e2[tfn_pkg::AXIS_Z] * e1[tfn_pkg::AXIS_X];
			c[tfn_pkg::AXIS_Z] = e1[tfn_pkg::AXIS_X] * e2[tfn_pkg::AXIS_Y]
				- e2[tfn_pkg::AXIS_X] * e1[tfn_pkg::AXIS_Y];
			sum = '0;
			for (int a = 0; a < tfn_pkg::AXES; a++) begin
				mag[a] = (c[a] < 0) ? 128'(-c[a]) : 128'(c[a]);
				sum += mag[a] * mag[a];
			end
			n.degenerate = (sum == 0);
			for (int a = 0; a < tfn_pkg::AXES; a++)
				n.comp[a] = '0;
			if (n.degenerate)
				return n;
			// The root stays below 2^34, so the search starts a little above that.
			len = '0;
			for (int b = 40; b >= 0; b--) begin
				trial = len | (128'd1 << b);
				if (trial * trial <= sum)
					len = trial;
			end
			for (int a = 0; a < tfn_pkg::AXES; a++) begin
				quot = (mag[a] << FB) / len;
				n.comp[a] = (c[a] < 0) ? -OW'(quot) : OW'(quot);
			end
			return n;
		endfunction

		function void note_face(face_t f);
			pending = {pending, unit_normal(f)};
		endfunction

		function void check_normal(logic [OUT_W-1:0] data, logic degen);
			normal_t want;
			logic signed [OW-1:0] got;
			if (pending.size() == 0) begin
				$error("result transaction with no face outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int a = 0; a < tfn_pkg::AXES; a++) begin
				got = data[a * OW +: OW];
				if (got !== want.comp[a]) begin
					$error("normal_%s: expected %0d, got %0d",
						(a == tfn_pkg::AXIS_X) ? "x" : (a == tfn_pkg::AXIS_Y) ? "y" : "z",
						want.comp[a], got);
					errors++;
				end
			end
			if (degen !== want.degenerate) begin
				$error("degenerate: expected %0b, got %0b", want.degenerate, degen);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// normal_x, normal_y, normal_z, zero fill
	logic [OUT_W-1:0] m_axis_tdata;
	// degenerate
	logic             m_axis_tuser;

	face_normal_board board;
	bit               calm;     // set for the closing stretch with no idling
	int               quiet;    // cycles since the last transaction on either side

	triangle_face_normal #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Presents one face and holds it until the block takes it. The input is
	// recorded on the scoreboard at the edge where the transaction happens.
	task automatic send_face(face_t f);
		logic [IN_W-1:0] word;
		int              gap;
		word = '0;
		for (int k = 0; k < tfn_pkg::COORDS; k++)
			word[k * CW +: CW] = f[k];
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		board.note_face(f);
	endtask

	task automatic send_coords(int v0x, int v0y, int v0z, int v1x, int v1y, int v1z,
			int v2x, int v2y, int v2z);
		face_t f;
		f = '{coord_t'(v0x), coord_t'(v0y), coord_t'(v0z), coord_t'(v1x), coord_t'(v1y),
			coord_t'(v1z), coord_t'(v2x), coord_t'(v2y), coord_t'(v2z)};
		send_face(f);
	endtask

	// A random face drawn from a few families: full range, small triangles near a
	// random point, collinear vertices and coincident vertices.
	task automatic send_random_face();
		face_t f;
		int    mode, k1, k2;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < tfn_pkg::COORDS; k++)
			f[k] = coord_t'($urandom);
		if (mode >= 5 && mode <= 7) begin
			for (int k = 3; k < tfn_pkg::COORDS; k++)
				f[k] = f[k % 3] + coord_t'($signed($urandom_range(0, 64)) - 32);
		end else if (mode == 8) begin
			// Collinear: v2 - v0 is a whole multiple of v1 - v0.
			k1 = $urandom_range(0, 6) - 3;
			for (int a = 0; a < tfn_pkg::AXES; a++) begin
				k2 = $urandom_range(0, 2000) - 1000;
				f[a]     = coord_t'($urandom_range(0, 16000) - 8000);
				f[3 + a] = f[a] + coord_t'(k2);
				f[6 + a] = f[a] + coord_t'(k1 * k2);
			end
		end else if (mode == 9) begin
			for (int a = 0; a < tfn_pkg::AXES; a++)
				f[3 + a * ($urandom_range(0, 1))] = f[a];
			for (int a = 0; a < tfn_pkg::AXES; a++)
				f[6 + a] = f[a];
		end
		send_face(f);
	endtask

	// Result side: checks every transaction and stalls in random bursts.
	int stall_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_normal(m_axis_tdata, m_axis_tuser);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left    <= $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if (quiet >= HANG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		board         = new();
		calm          = 1'b0;
		quiet         = 0;
		stall_left    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed faces: coincident, collinear, axis planes, extreme spans.
		send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_coords(0, 0, 0, 100, 200, 300, 200, 400, 600);
		send_coords(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
		send_coords(0, 0, 0, 16384, 0, 0, 0, 16384, 0);
		send_coords(0, 0, 0, 0, 16384, 0, 16384, 0, 0);
		send_coords(0, 0, 0, 0, 16384, 0, 0, 0, 16384);
		send_coords(0, 0, 0, 0, 0, 16384, 0, 16384, 0);
		send_coords(0, 0, 0, 0, 0, 16384, 16384, 0, 0);
		send_coords(0, 0, 0, 16384, 0, 0, 0, 0, 16384);
		send_coords(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0);
		send_coords(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
		send_coords(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767);
		send_coords(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
		send_coords(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
		send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_coords(0, 0, 0, 1, 1, 0, 1, 0, 1);
		send_coords(5, -7, 3, 5, -7, 3, 900, 12, -4);
		send_coords(-1, -1, -1, 0, 0, 0, 1, 1, 1);
		send_coords(0, 0, 0, 32767, 1, 0, 1, 32767, 0);

		for (int i = 0; i < 700; i++) begin
			if (i == 560)
				calm = 1'b1;
			send_random_face();
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
